// ----- rtl/sucf_pkg.sv -----
// ----------------------------------------------------------------------------
// sucf_pkg: shared types and codes of the sensor UART command framer
// Transaction payload structs, opcodes, frame headers and response codes.
// ----------------------------------------------------------------------------
package sucf_pkg;

   // input function codes
   localparam logic FUNC_CMD = 1'b0;
   localparam logic FUNC_RX  = 1'b1;

   // command kinds
   localparam logic [1:0] CMD_READ     = 2'd0;
   localparam logic [1:0] CMD_BASELINE = 2'd1;
   localparam logic [1:0] CMD_NTC_RES  = 2'd2;
   localparam logic [1:0] CMD_NTC_B    = 2'd3;

   // command opcodes
   localparam logic [7:0] OP_READ     = 8'hA0;
   localparam logic [7:0] OP_BASELINE = 8'hA6;
   localparam logic [7:0] OP_NTC_RES  = 8'hA3;
   localparam logic [7:0] OP_NTC_B    = 8'hA5;

   // response frame headers
   localparam logic [7:0] HDR_DATA = 8'hAA;
   localparam logic [7:0] HDR_ACK  = 8'hAC;

   // result kinds
   localparam logic KIND_TX   = 1'b0;
   localparam logic KIND_RESP = 1'b1;

   // response error codes
   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_CHECKSUM = 2'd1;
   localparam logic [1:0] ERR_HEADER   = 2'd2;
   localparam logic [1:0] ERR_STATUS   = 2'd3;

   // bytes per frame, and bytes held before the closing byte
   localparam int FRAME_BYTES = 6;
   localparam int HOLD_BYTES  = FRAME_BYTES - 1;

   typedef struct packed {
      logic        func;
      logic [1:0]  command_kind;
      logic [31:0] command_value;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic [1:0]  response_error;
      logic        response_is_data;
      logic [15:0] conductivity_us;
      logic [15:0] temperature_cdeg;
      logic [7:0]  device_status;
   } rsp_type;

   typedef logic [FRAME_BYTES-1:0][7:0] tx_frame_type;

endpackage

// ----- rtl/sucf_tx_encode.sv -----
// ----------------------------------------------------------------------------
// sucf_tx_encode: command frame encoder
// Builds the six transmit bytes: opcode, big-endian payload, sum checksum.
// ----------------------------------------------------------------------------
module sucf_tx_encode (
   input  logic [1:0]            command_kind,
   input  logic [31:0]           command_value,
   output sucf_pkg::tx_frame_type frame
);
   import sucf_pkg::*;

   logic [31:0] payload;
   logic [7:0]  opcode;

   // opcode and payload per command kind
   always_comb begin
      case (command_kind)
         CMD_READ: begin
            opcode  = OP_READ;
            payload = 32'h0;
         end
         CMD_BASELINE: begin
            opcode  = OP_BASELINE;
            payload = 32'h0;
         end
         CMD_NTC_RES: begin
            opcode  = OP_NTC_RES;
            payload = command_value;
         end
         CMD_NTC_B: begin
            opcode  = OP_NTC_B;
            payload = {command_value[15:0], 16'h0};
         end
         default: begin
            opcode  = OP_READ;
            payload = 32'h0;
         end
      endcase
   end

   // frame byte 0 goes out first; byte 5 is the checksum
   always_comb begin
      frame[0] = opcode;
      frame[1] = payload[31:24];
      frame[2] = payload[23:16];
      frame[3] = payload[15:8];
      frame[4] = payload[7:0];
      frame[5] = opcode + payload[31:24] + payload[23:16] + payload[15:8]
               + payload[7:0];
   end

endmodule

// ----- rtl/sensor_uart_command_framer.sv -----
// ----------------------------------------------------------------------------
// sensor_uart_command_framer: host side of a six-byte sensor UART protocol
// Turns commands into transmit frames and received bytes into parsed
// measurement or acknowledge responses.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data (sucf_pkg::req_type)
//   rsp      out        rsp_valid/rsp_stall  rsp_data (sucf_pkg::rsp_type)
//
// A command yields six transmit results, one per cycle unless rsp_stall holds;
// a received byte yields nothing, or one response on the byte that closes a frame.
// One transaction per cycle is taken while the queue is empty or its last result
// is taken; a command holds the input until its last transmit result is taken.
// Synchronous active-high reset clears counts and state; no clearing pass.
// rsp_stall holds the current result; req_stall follows the queue fill.
// ----------------------------------------------------------------------------
module sensor_uart_command_framer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sucf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sucf_pkg::rsp_type rsp_data
);
   import sucf_pkg::*;

   localparam int CntW = $clog2(FRAME_BYTES + 1);
   localparam int IdxW = $clog2(HOLD_BYTES);

   // output queue
   rsp_type                      out_ff, out_in;
   logic [HOLD_BYTES-1:0][7:0]   txq_ff, txq_in;
   logic [CntW-1:0]              count_ff, count_in;

   // receive state
   logic [7:0]                   rx_frame_ff [HOLD_BYTES];
   logic [CntW-1:0]              rx_count_ff, rx_count_in;
   logic [7:0]                   rx_sum_ff, rx_sum_in;
   logic                         expect_ff, expect_in;

   logic                         pop, acc, rx_close, rx_hold;
   tx_frame_type                 tx_frame;
   rsp_type                      resp;

   // handshake
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = !((count_ff == '0) || ((count_ff == CntW'(1)) && pop));
   assign acc       = req_valid && !req_stall;
   assign rsp_data  = out_ff;

   assign rx_close = (rx_count_ff >= CntW'(HOLD_BYTES));
   assign rx_hold  = acc && (req_data.func == FUNC_RX) && !rx_close;

   sucf_tx_encode u_tx_encode (
      .command_kind  (req_data.command_kind),
      .command_value (req_data.command_value),
      .frame         (tx_frame)
   );

   // response parse on the closing byte
   always_comb begin
      resp             = '0;
      resp.result_kind = KIND_RESP;
      resp.response_is_data = expect_ff;
      if (rx_sum_ff != req_data.rx_byte) begin
         resp.response_error = ERR_CHECKSUM;
      end else if (expect_ff) begin
         if (rx_frame_ff[0] != HDR_DATA) begin
            resp.response_error = ERR_HEADER;
         end else begin
            resp.conductivity_us  = {rx_frame_ff[1], rx_frame_ff[2]};
            resp.temperature_cdeg = {rx_frame_ff[3], rx_frame_ff[4]};
         end
      end else begin
         if (rx_frame_ff[0] != HDR_ACK) begin
            resp.response_error = ERR_HEADER;
         end else begin
            resp.device_status = rx_frame_ff[1];
            if (rx_frame_ff[1] != 8'h00) begin
               resp.response_error = ERR_STATUS;
            end
         end
      end
   end

   // output queue next state
   always_comb begin
      out_in   = out_ff;
      txq_in   = txq_ff;
      count_in = count_ff;
      if (pop) begin
         count_in       = count_ff - CntW'(1);
         out_in.tx_byte = txq_ff[0];
         out_in.tx_last = (count_ff == CntW'(2));
         txq_in         = {8'h00, txq_ff[HOLD_BYTES-1:1]};
      end
      if (acc) begin
         if (req_data.func == FUNC_CMD) begin
            out_in             = '0;
            out_in.result_kind = KIND_TX;
            out_in.tx_byte     = tx_frame[0];
            txq_in             = tx_frame[FRAME_BYTES-1:1];
            count_in           = CntW'(FRAME_BYTES);
         end else if (rx_close) begin
            out_in   = resp;
            count_in = CntW'(1);
         end
      end
   end

   // receive state next
   always_comb begin
      rx_count_in = rx_count_ff;
      rx_sum_in   = rx_sum_ff;
      expect_in   = expect_ff;
      if (acc) begin
         if (req_data.func == FUNC_CMD) begin
            expect_in = (req_data.command_kind == CMD_READ);
         end else if (rx_close) begin
            rx_count_in = '0;
            rx_sum_in   = 8'h00;
         end else begin
            rx_count_in = rx_count_ff + CntW'(1);
            rx_sum_in   = rx_sum_ff + req_data.rx_byte;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rx_count_ff <= '0;
         rx_sum_ff   <= 8'h00;
         expect_ff   <= 1'b1;
      end else begin
         count_ff    <= count_in;
         rx_count_ff <= rx_count_in;
         rx_sum_ff   <= rx_sum_in;
         expect_ff   <= expect_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      txq_ff <= txq_in;
   end

   // frame byte store, written only while the frame fills
   always_ff @(posedge clock) begin
      if (rx_hold) begin
         rx_frame_ff[rx_count_ff[IdxW-1:0]] <= req_data.rx_byte;
      end
   end

   // checks
   a_rx_count_range: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= CntW'(HOLD_BYTES))
      else $error("receive count beyond frame hold");

   a_cmd_fills_queue: assert property (@(posedge clock) disable iff (reset)
      (acc && req_data.func == FUNC_CMD) |=> (count_ff == CntW'(FRAME_BYTES)))
      else $error("command did not load six transmit results");

   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_TX && rsp_data.tx_last)
         |-> (count_ff == CntW'(1)))
      else $error("tx_last shown before the final queued byte");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (pop && count_ff == CntW'(1) && !req_valid) |=> !rsp_valid)
      else $error("result repeated after the queue drained");

endmodule

// ----- sim/sensor_uart_command_framer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_uart_command_framer_tb: self-checking bench for the command framer
// Drives commands and received response bytes with random gaps, predicts the
// transmit bytes and parsed responses, and checks every result in order.
// ----------------------------------------------------------------------------
module sensor_uart_command_framer_tb;
   import sucf_pkg::*;

   localparam int ITEM_TARGET     = 410;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int TAIL_CYCLES     = 20;

   // ------------------------------------------------------------------------
   // Scoreboard: predicts the framer and checks results in arrival order
   // ------------------------------------------------------------------------
   class framer_scoreboard;
      rsp_type    due_results[$];
      logic [7:0] held_bytes [HOLD_BYTES];
      int         held_count;
      logic [7:0] held_sum;
      logic       awaiting_data;
      int         failures;
      int         checked;
      int         commands_seen;
      int         by_error [4];

      function new();
         held_count    = 0;
         held_sum      = 8'h00;
         awaiting_data = 1'b1;   // reset state: a measurement frame is expected
         failures      = 0;
         checked       = 0;
         commands_seen = 0;
         foreach (held_bytes[i]) held_bytes[i] = 8'h00;
         foreach (by_error[i]) by_error[i] = 0;
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction

      // accepted input transaction: work out the results it causes
      function void note_request(req_type item);
         logic [31:0] payload;
         logic [7:0]  cmd_bytes [FRAME_BYTES];
         logic [7:0]  csum;
         logic [1:0]  err;
         logic [15:0] cond;
         logic [15:0] temp;
         logic [7:0]  status;
         rsp_type     r;
         if (item.func == FUNC_CMD) begin
            case (item.command_kind)
               CMD_READ: begin
                  cmd_bytes[0] = OP_READ;
                  payload      = 32'h0;
               end
               CMD_BASELINE: begin
                  cmd_bytes[0] = OP_BASELINE;
                  payload      = 32'h0;
               end
               CMD_NTC_RES: begin
                  cmd_bytes[0] = OP_NTC_RES;
                  payload      = item.command_value;
               end
               CMD_NTC_B: begin
                  // only the low half of the value is sent, in the upper half
                  cmd_bytes[0] = OP_NTC_B;
                  payload      = {item.command_value[15:0], 16'h0000};
               end
               default: begin
                  cmd_bytes[0] = OP_READ;
                  payload      = 32'h0;
               end
            endcase
            cmd_bytes[1] = payload[31:24];
            cmd_bytes[2] = payload[23:16];
            cmd_bytes[3] = payload[15:8];
            cmd_bytes[4] = payload[7:0];
            csum = 8'h00;
            for (int i = 0; i < HOLD_BYTES; i++) csum = csum + cmd_bytes[i];
            cmd_bytes[HOLD_BYTES] = csum;
            for (int i = 0; i < FRAME_BYTES; i++) begin
               r             = '0;
               r.result_kind = KIND_TX;
               r.tx_byte     = cmd_bytes[i];
               r.tx_last     = (i == FRAME_BYTES - 1);
               due_results.push_back(r);
            end
            // a partly received frame is left as it is
            awaiting_data = (item.command_kind == CMD_READ);
            commands_seen++;
         end else if (held_count < HOLD_BYTES) begin
            held_bytes[held_count] = item.rx_byte;
            held_sum   = held_sum + item.rx_byte;
            held_count = held_count + 1;
         end else begin
            // closing byte: checksum first, then header, then status
            err    = ERR_OK;
            cond   = 16'h0;
            temp   = 16'h0;
            status = 8'h0;
            if (held_sum != item.rx_byte) begin
               err = ERR_CHECKSUM;
            end else if (awaiting_data) begin
               if (held_bytes[0] != HDR_DATA) begin
                  err = ERR_HEADER;
               end else begin
                  cond = {held_bytes[1], held_bytes[2]};
                  temp = {held_bytes[3], held_bytes[4]};
               end
            end else begin
               if (held_bytes[0] != HDR_ACK) begin
                  err = ERR_HEADER;
               end else begin
                  status = held_bytes[1];
                  if (status != 8'h00) err = ERR_STATUS;
               end
            end
            r                  = '0;
            r.result_kind      = KIND_RESP;
            r.response_error   = err;
            r.response_is_data = awaiting_data;
            r.conductivity_us  = cond;
            r.temperature_cdeg = temp;
            r.device_status    = status;
            due_results.push_back(r);
            by_error[err]++;
            held_count = 0;
            held_sum   = 8'h00;
         end
      endfunction

      function int field_diff(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
         end
         return 0;
      endfunction

      // accepted result transaction: compare with the oldest prediction
      function void check_result(rsp_type got);
         rsp_type want;
         int      bad;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            failures++;
            return;
         end
         want = due_results.pop_front();
         bad  = 0;
         bad += field_diff("result_kind", 32'(want.result_kind), 32'(got.result_kind));
         bad += field_diff("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
         bad += field_diff("tx_last", 32'(want.tx_last), 32'(got.tx_last));
         bad += field_diff("response_error", 32'(want.response_error),
                           32'(got.response_error));
         bad += field_diff("response_is_data", 32'(want.response_is_data),
                           32'(got.response_is_data));
         bad += field_diff("conductivity_us", 32'(want.conductivity_us),
                           32'(got.conductivity_us));
         bad += field_diff("temperature_cdeg", 32'(want.temperature_cdeg),
                           32'(got.temperature_cdeg));
         bad += field_diff("device_status", 32'(want.device_status),
                           32'(got.device_status));
         if (bad != 0) failures++;
         checked++;
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   framer_scoreboard sb = new();

   int   items_sent = 0;
   int   rx_pos     = 0;      // position of the next received byte in its frame
   logic gen_read   = 1'b1;   // last command issued was a read
   logic quiet      = 1'b0;   // no idling on either side
   int   hold_asked = 0;
   int   hold_seen  = 0;
   int   hold_left  = 0;

   sensor_uart_command_framer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stall: random idling, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 20);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // one input transaction; returns just after the accepting edge
   task automatic push_req(input req_type item);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
      items_sent++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic push_cmd(input logic [1:0] kind, input logic [31:0] value);
      req_type it;
      it.func          = FUNC_CMD;
      it.command_kind  = kind;
      it.command_value = value;
      it.rx_byte       = 8'($urandom_range(0, 255));
      push_req(it);
      gen_read = (kind == CMD_READ);
   endtask

   task automatic push_rx(input logic [7:0] b);
      req_type it;
      it.func          = FUNC_RX;
      it.command_kind  = 2'($urandom_range(0, 3));
      it.command_value = $urandom;
      it.rx_byte       = b;
      push_req(it);
      rx_pos = (rx_pos == FRAME_BYTES - 1) ? 0 : rx_pos + 1;
   endtask

   // whole response frame; a bad checksum is the true sum plus a nonzero skew
   task automatic push_frame(input logic [7:0] head, input logic [31:0] body,
                             input bit sum_ok);
      logic [7:0] csum;
      logic [7:0] skew;
      csum = head + body[31:24] + body[23:16] + body[15:8] + body[7:0];
      skew = 8'($urandom_range(1, 255));
      push_rx(head);
      push_rx(body[31:24]);
      push_rx(body[23:16]);
      push_rx(body[15:8]);
      push_rx(body[7:0]);
      push_rx(sum_ok ? csum : csum + skew);
   endtask

   function automatic logic [31:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 32'h0000_0000;
      if (roll < 20) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // mostly well-formed frames matching the last command, some corrupted
   task automatic push_random_frame();
      logic [7:0]  head;
      logic [31:0] body;
      int          roll;
      while (rx_pos != 0) push_rx(8'($urandom_range(0, 255)));
      roll = $urandom_range(0, 99);
      if (roll < 85) head = gen_read ? HDR_DATA : HDR_ACK;
      else if (roll < 93) head = gen_read ? HDR_ACK : HDR_DATA;
      else head = 8'($urandom_range(0, 255));
      body = pick_value();
      if (!gen_read && $urandom_range(0, 99) < 60) body[31:24] = 8'h00;
      push_frame(head, body, $urandom_range(0, 99) < 85);
   endtask

   // run limit
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // main sequence
   initial begin
      int pick;
      bit held_once;
      bit drained_once;
      held_once    = 0;
      drained_once = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: measurement frame straight after reset, all-ones payload
      push_frame(HDR_DATA, 32'hFFFF_FFFF, 1);
      push_cmd(CMD_NTC_RES, 32'hFFFF_FFFF);
      // command in the middle of a frame, with an oversized B value
      push_rx(HDR_ACK);
      push_rx(8'h00);
      push_cmd(CMD_NTC_B, 32'hABCD_1234);
      push_rx(8'h12);
      push_rx(8'h34);
      push_rx(8'h56);
      push_rx(HDR_ACK + 8'h12 + 8'h34 + 8'h56);
      push_cmd(CMD_BASELINE, 32'h0000_0000);
      // checksum error beats a bad header
      push_frame(HDR_DATA, 32'h0000_0000, 0);
      // bad header beats a nonzero status
      push_frame(HDR_DATA, 32'h5A00_0000, 1);
      release_req();
      wait_drained();

      // random traffic
      while (items_sent < ITEM_TARGET) begin
         if (!held_once && items_sent >= 150) begin
            // receiver holds off while commands keep coming
            quiet      = 1'b1;
            hold_asked = hold_asked + 1;
            held_once  = 1;
         end
         if (quiet && items_sent >= 260) quiet = 1'b0;
         if (!drained_once && items_sent >= 330) begin
            release_req();
            wait_drained();
            drained_once = 1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            push_cmd(2'($urandom_range(0, 3)), pick_value());
            push_random_frame();
         end else if (pick < 78) begin
            push_random_frame();
         end else if (pick < 88) begin
            push_cmd(2'($urandom_range(0, 3)), pick_value());
         end else begin
            repeat ($urandom_range(1, 4)) push_rx(8'($urandom_range(0, 255)));
         end
      end

      release_req();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d transactions: %0d commands, %0d results checked.",
               items_sent, sb.commands_seen, sb.checked);
      $display("Responses: %0d ok, %0d checksum, %0d header, %0d status errors.",
               sb.by_error[ERR_OK], sb.by_error[ERR_CHECKSUM], sb.by_error[ERR_HEADER],
               sb.by_error[ERR_STATUS]);
      if (sb.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/sucf_pkg.sv
rtl/sucf_tx_encode.sv
rtl/sensor_uart_command_framer.sv
sim/sensor_uart_command_framer_tb.sv
